>>> rtl/core/sbad_pkg.sv
package sbad_pkg;

  localparam int BIN_W    = 32;
  localparam int CHAR_W   = 8;
  localparam int NUM_DIG  = 10;
  localparam int BCD_W    = 4 * NUM_DIG;
  localparam int CNT_W    = $clog2(BIN_W);
  localparam int DIG_W    = $clog2(NUM_DIG + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef logic [BCD_W-1:0] bcd_t;

  function automatic bcd_t bcd_adjust(input bcd_t d);
    bcd_t r;
    r = d;
    for (int i = 0; i < NUM_DIG; i++) begin
      if (d[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = d[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/sbad_if.sv
interface sbad_bin_if import sbad_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [BIN_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sbad_char_if import sbad_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

>>> rtl/core/signed_binary_to_ascii_decimal_unit.sv
// Signed binary to ASCII decimal text.
// in_word (sink): one signed 32-bit value per word, taken when valid and ready.
// out_char (source): the decimal text of that value, one ASCII character per
// word, most significant digit first, a leading '-' for negative values and
// last set on the final character. Zero gives a single '0'.
// The value is shifted bit-serially through a double-dabble BCD register,
// one bit per cycle. Then the minus sign is loaded when the value is negative,
// the leading zero scan drops the leading zero digits (up to 9), and the
// printed characters are loaded one at a time; the sign and each character
// wait for a free output register. A new word is taken only after the last
// character of the previous one is loaded.
// in_word.ready is high only while no conversion is running; it rises again
// as soon as the last character is loaded into the output register.
// A stalled receiver holds the output register and the block waits with it;
// no character is dropped or repeated.
// Reset clears the control state and the output valid; any item in flight
// is discarded.
module signed_binary_to_ascii_decimal_unit import sbad_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  sbad_bin_if.sink         in_word,
  sbad_char_if.source      out_char
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_SKIP,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [BIN_W-1:0]    bin_r, bin_nxt;
  bcd_t                bcd_r, bcd_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DIG_W-1:0]    dig_r, dig_nxt;
  logic                neg_r, neg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_character_r, out_character_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_fire;
  logic                slot_free;
  logic [BIN_W-1:0]    raw;
  logic [3:0]          top_dig;
  bcd_t                bcd_adj;

  assign raw       = $unsigned(in_word.value);
  assign in_fire   = in_word.valid && in_word.ready;
  assign slot_free = !out_valid_r || out_char.ready;
  assign top_dig   = bcd_r[BCD_W-1 -: 4];
  assign bcd_adj   = bcd_adjust(bcd_r);

  assign in_word.ready      = (state_r == S_IDLE);
  assign out_char.valid     = out_valid_r;
  assign out_char.character = out_character_r;
  assign out_char.last      = out_last_r;

  always_comb begin
    state_nxt         = state_r;
    bin_nxt           = bin_r;
    bcd_nxt           = bcd_r;
    cnt_nxt           = cnt_r;
    dig_nxt           = dig_r;
    neg_nxt           = neg_r;
    out_valid_nxt     = out_valid_r;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;

    if (out_valid_r && out_char.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          neg_nxt   = raw[BIN_W-1];
          bin_nxt   = raw[BIN_W-1] ? (~raw + 1'b1) : raw;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[BIN_W-1]};
        bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(BIN_W - 1)) begin
          dig_nxt   = DIG_W'(NUM_DIG);
          state_nxt = neg_r ? S_SIGN : S_SKIP;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = CHAR_MINUS;
          out_last_nxt      = 1'b0;
          state_nxt         = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top_dig == 4'd0 && dig_r > DIG_W'(1)) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          dig_nxt = dig_r - 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = CHAR_ZERO + {4'd0, top_dig};
          out_last_nxt      = (dig_r == DIG_W'(1));
          bcd_nxt           = {bcd_r[BCD_W-5:0], 4'd0};
          dig_nxt           = dig_r - 1'b1;
          if (dig_r == DIG_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bin_r           <= bin_nxt;
    bcd_r           <= bcd_nxt;
    cnt_r           <= cnt_nxt;
    dig_r           <= dig_nxt;
    neg_r           <= neg_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_word.ready)
    else $error("input taken while conversion starts");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_character_r == CHAR_MINUS ||
                     (out_character_r >= CHAR_ZERO &&
                      out_character_r <= CHAR_ZERO + 8'd9)))
    else $error("illegal character emitted");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_character_r == CHAR_MINUS) |-> !out_last_r)
    else $error("minus sign marked last");

  a_conv_no_output_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV && !out_valid_r) |=> !out_valid_r)
    else $error("output loaded during conversion");

endmodule

>>> dv/signed_binary_to_ascii_decimal_checker.sv
module signed_binary_to_ascii_decimal_checker import sbad_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  sbad_bin_if   in_word,
  sbad_char_if  out_char,
  output int    fail_count,
  output int    chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  text_char_t text_q[$];
  text_char_t head;
  int         mismatches = 0;
  int         waiting    = 0;

  assign fail_count    = mismatches;
  assign chars_pending = waiting;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Queue the decimal text of one word, most significant digit first.
  function automatic void predict_text(input logic [BIN_W-1:0] raw);
    logic [BIN_W-1:0] mag;
    logic [3:0]       digit_rev [NUM_DIG];
    int               n;
    mag = raw[BIN_W-1] ? (~raw + 1'b1) : raw;
    if (mag == '0) begin
      text_q.push_back('{character: CHAR_ZERO, last: 1'b1});
      return;
    end
    n = 0;
    while (mag != '0) begin
      digit_rev[n] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      n++;
    end
    if (raw[BIN_W-1]) begin
      text_q.push_back('{character: CHAR_MINUS, last: 1'b0});
    end
    for (int i = n - 1; i >= 0; i--) begin
      text_q.push_back('{character: CHAR_ZERO + CHAR_W'(digit_rev[i]), last: (i == 0)});
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      text_q.delete();
    end else begin
      if (out_char.valid && out_char.ready) begin
        if (text_q.size() == 0) begin
          report_mismatch($sformatf("char %h last %b with nothing expected",
                                    out_char.character, out_char.last));
        end else begin
          head = text_q.pop_front();
          if (out_char.character !== head.character) begin
            report_mismatch($sformatf("character %h, expected %h",
                                      out_char.character, head.character));
          end
          if (out_char.last !== head.last) begin
            report_mismatch($sformatf("last %b on character %h, expected %b",
                                      out_char.last, head.character, head.last));
          end
        end
      end
      if (in_word.valid && in_word.ready) begin
        predict_text(in_word.value);
      end
    end
    waiting = text_q.size();
  end

endmodule

>>> dv/signed_binary_to_ascii_decimal_unit_test.sv
module signed_binary_to_ascii_decimal_unit_test import sbad_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 5;
  localparam int RANDOM_WORDS = 140;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 40;
  localparam int TAIL_CYCLES  = 60;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {RX_STEADY, RX_COIN, RX_RARE_STALL, RX_SLOW} rx_pace_t;

  logic     clk = 1'b0;
  logic     rst_n;
  int       fail_count;
  int       chars_pending;
  int       words_sent  = 0;
  int       cycle_count = 0;
  logic     hold_off    = 1'b0;
  rx_pace_t rx_pace     = RX_STEADY;
  int       rx_left     = 0;
  logic     rx_go;

  sbad_bin_if  in_word_if ();
  sbad_char_if out_char_if ();

  signed_binary_to_ascii_decimal_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word_if),
    .out_char (out_char_if)
  );

  signed_binary_to_ascii_decimal_checker i_text_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_word       (in_word_if),
    .out_char      (out_char_if),
    .fail_count    (fail_count),
    .chars_pending (chars_pending)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("signed_binary_to_ascii_decimal_unit_test: done, errors");
      $finish;
    end
  end

  task automatic offer_word(input logic signed [BIN_W-1:0] v);
    @(negedge clk);
    in_word_if.valid <= 1'b1;
    in_word_if.value <= v;
    do @(posedge clk); while (!in_word_if.ready);
    words_sent++;
  endtask

  task automatic idle_sender(input int cycles);
    @(negedge clk);
    in_word_if.valid <= 1'b0;
    in_word_if.value <= $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic logic signed [BIN_W-1:0] random_value();
    logic [BIN_W-1:0]        p;
    logic signed [BIN_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(0, 31);
      2: begin
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        v = p + $urandom_range(0, 2) - 1;
      end
      default: v = $urandom_range(0, 20);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  // Receiver pace changes now and then between steady, coin-flip, rare-stall and slow.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_pace = rx_pace_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    case (rx_pace)
      RX_STEADY:     rx_go = 1'b1;
      RX_COIN:       rx_go = ($urandom_range(0, 1) == 1);
      RX_RARE_STALL: rx_go = ($urandom_range(0, 7) != 0);
      default:       rx_go = ($urandom_range(0, 3) == 0);
    endcase
    out_char_if.ready <= rst_n && !hold_off && rx_go;
  end

  // Hold the receiver off while the sender keeps offering words.
  initial begin
    wait (words_sent >= HOLD_AFTER);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    logic signed [BIN_W-1:0] corners[$];
    int                      burst;
    rst_n             = 1'b0;
    in_word_if.valid  = 1'b0;
    in_word_if.value  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    corners = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
                32'sd100, -32'sd100, 32'sd999999999, 32'sd1000000000,
                -32'sd1000000000, 32'sd2147483647, -32'sd2147483647, 32'sh80000000,
                32'sd1234567890, -32'sd1234567890, 32'sd2000000000, -32'sd5};
    foreach (corners[i]) begin
      offer_word(corners[i]);
    end

    burst = 0;
    repeat (RANDOM_WORDS) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 8);
        idle_sender(($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8));
      end
      offer_word(random_value());
      burst--;
    end
    @(negedge clk);
    in_word_if.valid <= 1'b0;

    while (chars_pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("signed_binary_to_ascii_decimal_unit_test: done, clean");
    end else begin
      $display("signed_binary_to_ascii_decimal_unit_test: done, errors");
    end
    $finish;
  end

endmodule
